// ===== design/tscu_pkg.sv =====
// Shared types and constants for the Taylor sine/cosine unit.
// Holds the fixed-point widths, the control word layout and the reciprocal tables.
// No dependencies.
package tscu_pkg;

    localparam int FRAC_BITS = 24;
    localparam int MAX_TERMS = 16;

    localparam int ANGLE_W  = 27;
    localparam int AX_W     = 27;
    localparam int MAG_W    = 28;
    localparam int SUM_W    = 29;
    localparam int VALUE_W  = 28;
    localparam int THR_W    = 24;
    localparam int RECIP_W  = 30;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int SHIFT_W  = 6;
    localparam int COUNT_W  = $clog2(MAX_TERMS + 1);
    localparam int KIDX_W   = $clog2(MAX_TERMS);
    localparam int TIDX_W   = KIDX_W + 1;

    localparam logic [MAG_W-1:0] TERM_MAX = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0] ONE_MAG  = MAG_W'(64'd1 << FRAC_BITS);

    typedef enum logic
    {
        A_MAG,
        A_SCALED
    } a_sel_t;

    typedef enum logic
    {
        B_ANGLE,
        B_RECIP
    } b_sel_t;

    typedef enum logic [1:0]
    {
        BR_NEXT,
        BR_TEST,
        BR_END
    } branch_t;

    typedef struct packed
    {
        logic    mul_en;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        logic    div_en;
        logic    acc_en;
        logic    finish;
        branch_t br;
        logic [2:0] target;
    } ctrl_word_t;

    typedef struct packed
    {
        logic stop;
        logic last;
    } dp_status_t;

    // ceil(2^(28+l) / d) with 2^(l-1) < d <= 2^l: exact floor division of 28-bit values.
    // Entries 0..15 serve sine (d = n(n-1), n = 3,5,..), 16..31 cosine (n = 2,4,..).
    localparam logic [RECIP_W-1:0] RECIP_TABLE [2*MAX_TERMS] = '{
        RECIP_W'(((64'd1 << 31) + 64'd5)    / 64'd6),
        RECIP_W'(((64'd1 << 33) + 64'd19)   / 64'd20),
        RECIP_W'(((64'd1 << 34) + 64'd41)   / 64'd42),
        RECIP_W'(((64'd1 << 35) + 64'd71)   / 64'd72),
        RECIP_W'(((64'd1 << 35) + 64'd109)  / 64'd110),
        RECIP_W'(((64'd1 << 36) + 64'd155)  / 64'd156),
        RECIP_W'(((64'd1 << 36) + 64'd209)  / 64'd210),
        RECIP_W'(((64'd1 << 37) + 64'd271)  / 64'd272),
        RECIP_W'(((64'd1 << 37) + 64'd341)  / 64'd342),
        RECIP_W'(((64'd1 << 37) + 64'd419)  / 64'd420),
        RECIP_W'(((64'd1 << 37) + 64'd505)  / 64'd506),
        RECIP_W'(((64'd1 << 38) + 64'd599)  / 64'd600),
        RECIP_W'(((64'd1 << 38) + 64'd701)  / 64'd702),
        RECIP_W'(((64'd1 << 38) + 64'd811)  / 64'd812),
        RECIP_W'(((64'd1 << 38) + 64'd929)  / 64'd930),
        RECIP_W'(((64'd1 << 39) + 64'd1055) / 64'd1056),
        RECIP_W'(((64'd1 << 29) + 64'd1)    / 64'd2),
        RECIP_W'(((64'd1 << 32) + 64'd11)   / 64'd12),
        RECIP_W'(((64'd1 << 33) + 64'd29)   / 64'd30),
        RECIP_W'(((64'd1 << 34) + 64'd55)   / 64'd56),
        RECIP_W'(((64'd1 << 35) + 64'd89)   / 64'd90),
        RECIP_W'(((64'd1 << 36) + 64'd131)  / 64'd132),
        RECIP_W'(((64'd1 << 36) + 64'd181)  / 64'd182),
        RECIP_W'(((64'd1 << 36) + 64'd239)  / 64'd240),
        RECIP_W'(((64'd1 << 37) + 64'd305)  / 64'd306),
        RECIP_W'(((64'd1 << 37) + 64'd379)  / 64'd380),
        RECIP_W'(((64'd1 << 37) + 64'd461)  / 64'd462),
        RECIP_W'(((64'd1 << 38) + 64'd551)  / 64'd552),
        RECIP_W'(((64'd1 << 38) + 64'd649)  / 64'd650),
        RECIP_W'(((64'd1 << 38) + 64'd755)  / 64'd756),
        RECIP_W'(((64'd1 << 38) + 64'd869)  / 64'd870),
        RECIP_W'(((64'd1 << 38) + 64'd991)  / 64'd992)
    };

    localparam logic [SHIFT_W-1:0] SHIFT_TABLE [2*MAX_TERMS] = '{
        6'd31, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36, 6'd36, 6'd37,
        6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd38, 6'd38, 6'd39,
        6'd29, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd36, 6'd36,
        6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd38, 6'd38, 6'd38
    };

endpackage

// ===== design/tscu_seq.sv =====
// Microcode sequencer: step counter, control store and branch logic.
// Depends on tscu_pkg for the control word and datapath status types.
module tscu_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  tscu_pkg::dp_status_t  status,
    output tscu_pkg::ctrl_word_t  ctrl,
    output logic                  busy
);

    localparam logic [2:0] PC_MUL_FIRST = 3'd0;
    localparam logic [2:0] PC_MUL_LOOP  = 3'd1;
    localparam logic [2:0] PC_MUL_RECIP = 3'd2;
    localparam logic [2:0] PC_DIVIDE    = 3'd3;
    localparam logic [2:0] PC_ACCUM     = 3'd4;
    localparam logic [2:0] PC_FINISH    = 3'd5;

    logic [2:0]            pc_reg;
    logic [2:0]            pc_next;
    logic                  busy_reg;
    logic                  busy_next;
    tscu_pkg::ctrl_word_t  rom_word;

    always_comb
    begin
        rom_word = '{mul_en: 1'b0, a_sel: tscu_pkg::A_MAG, b_sel: tscu_pkg::B_ANGLE,
                     div_en: 1'b0, acc_en: 1'b0, finish: 1'b0,
                     br: tscu_pkg::BR_END, target: PC_FINISH};
        case (pc_reg)
            PC_MUL_FIRST:
            begin
                rom_word.mul_en = 1'b1;
                rom_word.br     = tscu_pkg::BR_NEXT;
            end
            PC_MUL_LOOP:
            begin
                rom_word.mul_en = 1'b1;
                rom_word.a_sel  = tscu_pkg::A_SCALED;
                rom_word.br     = tscu_pkg::BR_NEXT;
            end
            PC_MUL_RECIP:
            begin
                rom_word.mul_en = 1'b1;
                rom_word.a_sel  = tscu_pkg::A_SCALED;
                rom_word.b_sel  = tscu_pkg::B_RECIP;
                rom_word.br     = tscu_pkg::BR_NEXT;
            end
            PC_DIVIDE:
            begin
                rom_word.div_en = 1'b1;
                rom_word.br     = tscu_pkg::BR_NEXT;
            end
            PC_ACCUM:
            begin
                rom_word.acc_en = 1'b1;
                rom_word.mul_en = 1'b1;
                rom_word.br     = tscu_pkg::BR_TEST;
                rom_word.target = PC_MUL_LOOP;
            end
            PC_FINISH:
            begin
                rom_word.finish = 1'b1;
            end
            default:
            begin
                rom_word.br = tscu_pkg::BR_END;
            end
        endcase
    end

    always_comb
    begin
        ctrl = rom_word;
        if (!busy_reg)
        begin
            ctrl.mul_en = 1'b0;
            ctrl.div_en = 1'b0;
            ctrl.acc_en = 1'b0;
            ctrl.finish = 1'b0;
        end
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (go)
        begin
            pc_next   = PC_MUL_FIRST;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (rom_word.br)
                tscu_pkg::BR_NEXT: pc_next = pc_reg + 3'd1;
                tscu_pkg::BR_TEST:
                begin
                    if (status.stop || status.last)
                        pc_next = PC_FINISH;
                    else
                        pc_next = rom_word.target;
                end
                tscu_pkg::BR_END:  busy_next = 1'b0;
                default:           busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_MUL_FIRST;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== design/tscu_datapath.sv =====
// Datapath: shared multiplier, term magnitude, running sum, counters and result registers.
// Depends on tscu_pkg for widths, reciprocal tables and control types.
module tscu_datapath
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     go,
    input  logic                                     command,
    input  logic signed [tscu_pkg::ANGLE_W-1:0]      angle,
    input  logic                                     cfg_write_en,
    input  logic [tscu_pkg::THR_W-1:0]               cfg_write_data,
    input  tscu_pkg::ctrl_word_t                     ctrl,
    output tscu_pkg::dp_status_t                     status,
    output logic signed [tscu_pkg::VALUE_W-1:0]      value,
    output logic [tscu_pkg::COUNT_W-1:0]             terms_used,
    output logic                                     limit_hit,
    output logic                                     done
);

    localparam int HI_W = tscu_pkg::PROD_W - tscu_pkg::FRAC_BITS;

    logic [tscu_pkg::THR_W-1:0]          thr_reg;
    logic [tscu_pkg::AX_W-1:0]           ax_reg;
    logic                                cos_reg;
    logic [tscu_pkg::MAG_W-1:0]          mag_reg;
    logic [tscu_pkg::PROD_W-1:0]         prod_reg;
    logic signed [tscu_pkg::SUM_W-1:0]   sum_reg;
    logic [tscu_pkg::COUNT_W-1:0]        count_reg;
    logic                                sign_reg;
    logic                                limit_reg;
    logic signed [tscu_pkg::VALUE_W-1:0] value_reg;
    logic [tscu_pkg::COUNT_W-1:0]        terms_reg;
    logic                                limit_hit_reg;
    logic                                done_reg;

    logic [tscu_pkg::AX_W-1:0]           ax_in;
    logic [HI_W-1:0]                     prod_hi;
    logic [tscu_pkg::MAG_W-1:0]          scaled;
    logic [tscu_pkg::TIDX_W-1:0]         tidx;
    logic [tscu_pkg::MAG_W-1:0]          mul_a;
    logic [tscu_pkg::RECIP_W-1:0]        mul_b;
    logic [tscu_pkg::PROD_W-1:0]         prod_next;
    logic [tscu_pkg::PROD_W-1:0]         quot_full;
    logic signed [tscu_pkg::SUM_W:0]     term;
    logic signed [tscu_pkg::SUM_W:0]     sum_wide;
    logic signed [tscu_pkg::SUM_W-1:0]   sum_next;
    logic signed [tscu_pkg::VALUE_W-1:0] value_next;

    assign ax_in   = angle[tscu_pkg::ANGLE_W-1] ? tscu_pkg::AX_W'(-angle)
                                                : tscu_pkg::AX_W'(angle);
    assign prod_hi = prod_reg[tscu_pkg::PROD_W-1:tscu_pkg::FRAC_BITS];
    assign scaled  = (|prod_hi[HI_W-1:tscu_pkg::MAG_W]) ? tscu_pkg::TERM_MAX
                                                        : prod_hi[tscu_pkg::MAG_W-1:0];
    assign tidx    = {cos_reg, count_reg[tscu_pkg::KIDX_W-1:0]};

    assign mul_a     = (ctrl.a_sel == tscu_pkg::A_SCALED) ? scaled : mag_reg;
    assign mul_b     = (ctrl.b_sel == tscu_pkg::B_RECIP) ? tscu_pkg::RECIP_TABLE[tidx]
                                                         : tscu_pkg::RECIP_W'(ax_reg);
    assign prod_next = tscu_pkg::PROD_W'(mul_a) * tscu_pkg::PROD_W'(mul_b);
    assign quot_full = prod_reg >> tscu_pkg::SHIFT_TABLE[tidx];

    assign term     = sign_reg ? -$signed({2'b00, mag_reg}) : $signed({2'b00, mag_reg});
    assign sum_wide = (tscu_pkg::SUM_W + 1)'(sum_reg) + term;
    assign sum_next = (sum_wide[tscu_pkg::SUM_W] != sum_wide[tscu_pkg::SUM_W-1])
                    ? {sum_wide[tscu_pkg::SUM_W], {(tscu_pkg::SUM_W-1){~sum_wide[tscu_pkg::SUM_W]}}}
                    : sum_wide[tscu_pkg::SUM_W-1:0];

    assign value_next = (sum_reg[tscu_pkg::SUM_W-1] != sum_reg[tscu_pkg::SUM_W-2])
                      ? {sum_reg[tscu_pkg::SUM_W-1],
                         {(tscu_pkg::VALUE_W-1){~sum_reg[tscu_pkg::SUM_W-1]}}}
                      : sum_reg[tscu_pkg::VALUE_W-1:0];

    assign status.stop = (mag_reg <= tscu_pkg::MAG_W'(thr_reg));
    assign status.last = (count_reg == tscu_pkg::COUNT_W'(tscu_pkg::MAX_TERMS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= tscu_pkg::THR_W'(17);
            done_reg  <= 1'b0;
            count_reg <= '0;
            limit_reg <= 1'b0;
            sign_reg  <= 1'b1;
        end
        else
        begin
            done_reg <= ctrl.finish;
            if (cfg_write_en)
                thr_reg <= cfg_write_data;
            if (go)
            begin
                count_reg <= '0;
                limit_reg <= 1'b0;
                sign_reg  <= command | ~angle[tscu_pkg::ANGLE_W-1];
            end
            else if (ctrl.acc_en)
            begin
                count_reg <= count_reg + tscu_pkg::COUNT_W'(1);
                limit_reg <= ~status.stop & status.last;
                sign_reg  <= ~sign_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ax_reg  <= ax_in;
            cos_reg <= command;
            if (command)
            begin
                mag_reg <= tscu_pkg::ONE_MAG;
                sum_reg <= tscu_pkg::SUM_W'(tscu_pkg::ONE_MAG);
            end
            else
            begin
                mag_reg <= tscu_pkg::MAG_W'(ax_in);
                sum_reg <= tscu_pkg::SUM_W'(angle);
            end
        end
        else
        begin
            if (ctrl.div_en)
                mag_reg <= quot_full[tscu_pkg::MAG_W-1:0];
            if (ctrl.acc_en)
                sum_reg <= sum_next;
        end
        if (ctrl.mul_en)
            prod_reg <= prod_next;
        if (ctrl.finish)
        begin
            value_reg     <= value_next;
            terms_reg     <= count_reg;
            limit_hit_reg <= limit_reg;
        end
    end

    assign value      = value_reg;
    assign terms_used = terms_reg;
    assign limit_hit  = limit_hit_reg;
    assign done       = done_reg;

endmodule

// ===== design/taylor_sine_cosine_unit_core.sv =====
// Top level of the Taylor sine/cosine unit: sequencer plus datapath.
// Depends on tscu_pkg, tscu_seq and tscu_datapath.
//
// Usage: raise start with command (0 sine, 1 cosine) and a signed Q3.24 angle; the
// transfer happens at a clock edge where start is high and busy is low. busy stays
// high while the series runs. The result (Q4.24 value, saturated, terms_used and
// limit_hit) sits on its ports when done pulses for one cycle; the outputs hold
// their values afterwards but only the done cycle marks a transfer. The receiver
// cannot stall: the result is taken at the edge that ends the done cycle.
// Each series adds N correction terms, 1 to 16. Each term takes four steps of the
// microcode program on the one shared 28x30 multiplier (two scaling products, one
// reciprocal product, one shift), with the next term's first product overlapped
// with the accumulate step. busy falls with done, so a new start is taken at the
// edge that ends the done cycle. stop_threshold is written through cfg_write_en and
// cfg_write_data; the user must write it only while idle, as the block itself does
// not enforce this. Reset sets it to 17 and returns the sequencer to idle with busy
// and done low.
module taylor_sine_cosine_unit_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 command,
    input  logic signed [tscu_pkg::ANGLE_W-1:0]  angle,
    input  logic                                 cfg_write_en,
    input  logic [tscu_pkg::THR_W-1:0]           cfg_write_data,
    output logic                                 done,
    output logic signed [tscu_pkg::VALUE_W-1:0]  value,
    output logic [tscu_pkg::COUNT_W-1:0]         terms_used,
    output logic                                 limit_hit
);

    logic                  go;
    tscu_pkg::ctrl_word_t  ctrl;
    tscu_pkg::dp_status_t  status;

    assign go = start & ~busy;

    tscu_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    tscu_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (go),
        .command        (command),
        .angle          (angle),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .ctrl           (ctrl),
        .status         (status),
        .value          (value),
        .terms_used     (terms_used),
        .limit_hit      (limit_hit),
        .done           (done)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted transfer did not raise busy");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_terms_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> terms_used != '0
                 && terms_used <= tscu_pkg::COUNT_W'(tscu_pkg::MAX_TERMS))
        else $error("terms_used out of range");

    a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && limit_hit |-> terms_used == tscu_pkg::COUNT_W'(tscu_pkg::MAX_TERMS))
        else $error("limit flagged before the term limit");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for taylor_sine_cosine_unit_core: sine and cosine series runs
// against a cycle-free series predictor, over several stop thresholds.
// Depends on tscu_pkg and the core RTL.
module tb_top;

    localparam logic CMD_SINE   = 1'b0;
    localparam logic CMD_COSINE = 1'b1;

    localparam longint MAG_CAP = (longint'(1) << tscu_pkg::MAG_W) - 1;
    localparam longint SUM_LO  = -(longint'(1) << (tscu_pkg::SUM_W - 1));
    localparam longint SUM_HI  = (longint'(1) << (tscu_pkg::SUM_W - 1)) - 1;
    localparam longint OUT_LO  = -(longint'(1) << (tscu_pkg::VALUE_W - 1));
    localparam longint OUT_HI  = (longint'(1) << (tscu_pkg::VALUE_W - 1)) - 1;

    typedef struct
    {
        logic                                 command;
        logic signed [tscu_pkg::ANGLE_W-1:0]  angle;
    } trig_cmd_t;

    typedef struct
    {
        logic signed [tscu_pkg::VALUE_W-1:0]  value;
        logic [tscu_pkg::COUNT_W-1:0]         terms_used;
        logic                                 limit_hit;
    } trig_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic                                 command = CMD_SINE;
    logic signed [tscu_pkg::ANGLE_W-1:0]  angle = '0;
    logic                                 cfg_write_en = 1'b0;
    logic [tscu_pkg::THR_W-1:0]           cfg_write_data = '0;
    logic                                 done;
    logic signed [tscu_pkg::VALUE_W-1:0]  value;
    logic [tscu_pkg::COUNT_W-1:0]         terms_used;
    logic                                 limit_hit;

    trig_cmd_t                    pending_cmds[$];
    trig_result_t                 expected_results[$];
    logic [tscu_pkg::THR_W-1:0]   stop_level = tscu_pkg::THR_W'(17);
    int                           idle_pct = 31;
    int                           sent_count = 0;
    int                           taken_count = 0;
    int                           mismatches = 0;

    taylor_sine_cosine_unit_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .angle          (angle),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .done           (done),
        .value          (value),
        .terms_used     (terms_used),
        .limit_hit      (limit_hit)
    );

    always #10 clk = ~clk;

    function automatic trig_result_t series_sine_cosine(
        logic cmd,
        logic signed [tscu_pkg::ANGLE_W-1:0] ang,
        logic [tscu_pkg::THR_W-1:0] thr);
        trig_result_t r;
        longint x;
        longint ax;
        longint mag;
        longint prod;
        longint sum;
        longint first;
        int n;
        int count;
        bit base_neg;
        bit flip_neg;
        bit running;
        bit limit;
        x = longint'(ang);
        ax = (x < 0) ? -x : x;
        if (cmd == CMD_COSINE)
        begin
            first = longint'(1) << tscu_pkg::FRAC_BITS;
            if (first > MAG_CAP)
                first = MAG_CAP;
            n = 2;
            base_neg = 1'b0;
        end
        else
        begin
            first = x;
            n = 3;
            base_neg = (x < 0);
        end
        mag = (first < 0) ? -first : first;
        sum = first;
        flip_neg = 1'b1;
        count = 0;
        running = 1'b1;
        limit = 1'b0;
        while (running)
        begin
            prod = (mag * ax) >> tscu_pkg::FRAC_BITS;
            if (prod > MAG_CAP)
                prod = MAG_CAP;
            prod = (prod * ax) >> tscu_pkg::FRAC_BITS;
            if (prod > MAG_CAP)
                prod = MAG_CAP;
            mag = prod / longint'(n * (n - 1));
            sum = sum + ((base_neg ^ flip_neg) ? -mag : mag);
            if (sum < SUM_LO)
                sum = SUM_LO;
            else if (sum > SUM_HI)
                sum = SUM_HI;
            count++;
            n += 2;
            flip_neg = ~flip_neg;
            if (mag <= longint'(thr))
                running = 1'b0;
            else if (count >= tscu_pkg::MAX_TERMS)
            begin
                limit = 1'b1;
                running = 1'b0;
            end
        end
        if (sum < OUT_LO)
            sum = OUT_LO;
        else if (sum > OUT_HI)
            sum = OUT_HI;
        r.value = sum[tscu_pkg::VALUE_W-1:0];
        r.terms_used = (count > (1 << tscu_pkg::COUNT_W) - 1) ? {tscu_pkg::COUNT_W{1'b1}}
                                                              : tscu_pkg::COUNT_W'(count);
        r.limit_hit = limit;
        return r;
    endfunction

    function automatic logic signed [tscu_pkg::ANGLE_W-1:0] pick_angle();
        logic signed [tscu_pkg::ANGLE_W-1:0] a;
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3: a = tscu_pkg::ANGLE_W'($urandom);
            4, 5, 6:    a = tscu_pkg::ANGLE_W'($urandom_range(0, 1 << tscu_pkg::FRAC_BITS));
            7:          a = tscu_pkg::ANGLE_W'($urandom_range(0, 4095));
            8:          a = tscu_pkg::ANGLE_W'(67108863 - $urandom_range(0, 4095));
            default:    a = tscu_pkg::ANGLE_W'($urandom_range(0, 16));
        endcase
        if (sel >= 4 && $urandom_range(1) == 1)
            a = -a;
        return a;
    endfunction

    task automatic queue_cmd(logic cmd, logic signed [tscu_pkg::ANGLE_W-1:0] ang);
        trig_cmd_t c;
        c.command = cmd;
        c.angle = ang;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_cmd(logic'($urandom_range(1)), pick_angle());
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic apply_threshold(logic [tscu_pkg::THR_W-1:0] level);
        wait_drained();
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= level;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // hold a presented command until its transfer, then advance
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && taken_count != sent_count)
            start <= 1'b1;
        else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
        begin
            start <= 1'b1;
            command <= pending_cmds[0].command;
            angle <= pending_cmds[0].angle;
            sent_count++;
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        trig_result_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result value %0d terms %0d limit %0d",
                             $time, value, terms_used, limit_hit);
                    mismatches++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (value !== e.value)
                    begin
                        $display("%0t: value expected %0d actual %0d", $time, e.value, value);
                        mismatches++;
                    end
                    if (terms_used !== e.terms_used)
                    begin
                        $display("%0t: terms_used expected %0d actual %0d",
                                 $time, e.terms_used, terms_used);
                        mismatches++;
                    end
                    if (limit_hit !== e.limit_hit)
                    begin
                        $display("%0t: limit_hit expected %0d actual %0d",
                                 $time, e.limit_hit, limit_hit);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(series_sine_cosine(command, angle, stop_level));
                void'(pending_cmds.pop_front());
                taken_count++;
            end
            if (cfg_write_en)
                stop_level = cfg_write_data;
        end
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_cmd(CMD_SINE, '0);
        queue_cmd(CMD_COSINE, '0);
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(67108863));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(-67108864));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(67108863));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(-67108864));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(16777216));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(-16777216));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(16777216));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(-16777216));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(26353589));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(-26353589));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(52707179));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(-52707179));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(1));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(-1));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(1));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(27'h2AAAAAA));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(27'h5555555));
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(50331648));

        apply_threshold('0);
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(67108863));
        queue_cmd(CMD_COSINE, tscu_pkg::ANGLE_W'(-67108864));
        queue_random(275);

        apply_threshold({tscu_pkg::THR_W{1'b1}});
        queue_cmd(CMD_SINE, tscu_pkg::ANGLE_W'(67108863));
        queue_cmd(CMD_COSINE, '0);
        queue_random(250);

        // long stretch with a back-to-back sender
        apply_threshold(tscu_pkg::THR_W'(17));
        idle_pct = 0;
        queue_random(300);

        apply_threshold(tscu_pkg::THR_W'($urandom));
        idle_pct = 31;
        queue_random(275);

        apply_threshold(tscu_pkg::THR_W'($urandom_range(0, 255)));
        queue_random(275);

        apply_threshold(tscu_pkg::THR_W'(1));
        queue_random(275);

        wait_drained();
        repeat (70) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/tscu_pkg.sv
design/tscu_seq.sv
design/tscu_datapath.sv
design/taylor_sine_cosine_unit_core.sv
tb/sv/tb_top.sv
